/* sv/i2ra_pkg.sv */
// ----------------------------------------------------------------------------
// i2ra_pkg
// Shared types and constants for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package i2ra_pkg;

   // radix select codes carried on the request tuser
   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_SEND
   } state_type;

   // request beat layout
   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USER_W  = 2;
   localparam int VALUE_W     = 32;
   localparam int VALUE_LSB   = 0;
   localparam int LIMIT_W     = 4;
   localparam int LIMIT_LSB   = 32;

   // response beat layout
   localparam int RSP_DATA_W  = 16;
   localparam int CHAR_W      = 7;
   localparam int COUNT_W     = 4;
   localparam int DIGIT_W     = 4;

   // x / 10 == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int          DEC_SHIFT = 35;
   localparam int          PROD_W    = 64;

   localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
   };

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
      return DIGIT_CHARS[d];
   endfunction

endpackage

/* sv/i2ra_divider.sv */
// ----------------------------------------------------------------------------
// i2ra_divider
// Divide-by-radix unit: one registered quotient and remainder per operand,
// valid in the cycle after the operand is presented. Decimal uses a
// reciprocal multiply, octal and hex are shifts.
// ----------------------------------------------------------------------------
module i2ra_divider #(
   parameter int VW = 32
) (
   input  logic                        clock,
   input  logic [VW-1:0]               x_in,
   input  i2ra_pkg::radix_type         radix_in,
   output logic [VW-1:0]               quot_out,
   output logic [i2ra_pkg::DIGIT_W-1:0] rem_out
);
   import i2ra_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [VW-1:0]     x_ff;
   radix_type         radix_ff;
   logic [VW-1:0]     dec_quot;
   logic [VW-1:0]     dec_back;

   assign prod_in = PROD_W'(VALUE_W'(x_in)) * PROD_W'(DEC_RECIP);

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      x_ff     <= x_in;
      radix_ff <= radix_in;
   end

   assign dec_quot = VW'(prod_ff[PROD_W-1:DEC_SHIFT]);
   // q * 10 as q*8 + q*2
   assign dec_back = (dec_quot << 3) + (dec_quot << 1);

   always_comb begin
      unique case (radix_ff)
         RADIX_DEC: begin
            quot_out = dec_quot;
            rem_out  = DIGIT_W'(x_ff - dec_back);
         end
         RADIX_OCT: begin
            quot_out = x_ff >> 3;
            rem_out  = {1'b0, x_ff[2:0]};
         end
         RADIX_HEX: begin
            quot_out = x_ff >> 4;
            rem_out  = x_ff[3:0];
         end
         default: begin
            quot_out = '0;
            rem_out  = '0;
         end
      endcase
   end

endmodule

/* sv/integer_to_radix_ascii.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Unsigned value to ASCII digits in decimal, octal or lower case hex.
// ----------------------------------------------------------------------------
// One request beat carries a value, a radix select and a digit limit; the
// block answers with one response beat per digit, most significant first,
// no leading zeros, zero as a single '0', tlast on the final digit and the
// digit count on every beat. A bad radix code, a zero limit or a value that
// needs more digits than the limit gives one error beat (tuser high, tlast
// high, data zero). Digits are produced least significant first by one
// shared divide-by-radix unit (reciprocal multiply, then remainder), kept in
// a small digit store and sent back in reverse. Response beats go out one
// per cycle while the sink keeps tready high. The request side is ready
// only between conversions.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] value, [35:32] max_digits, [39:36] zero
   input  logic [i2ra_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] op (radix select)
   input  logic [i2ra_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] digit_char, [10:7] digit_count, [15:11] zero
   output logic [i2ra_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] error
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import i2ra_pkg::*;

   localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int DEPTH = (VW + 2) / 3;
   localparam int IW    = $clog2(DEPTH);

   state_type            state_ff, state_in;
   logic [VW-1:0]        x_ff, x_in;
   radix_type            radix_ff, radix_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   cnt_next;
   logic [IW-1:0]        ptr_ff, ptr_in;
   logic [DIGIT_W-1:0]   digits_ff [DEPTH];
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_err_ff, rsp_err_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        div_quot;
   logic [DIGIT_W-1:0]   div_rem;
   logic                 req_ok;

   i2ra_divider #(
      .VW (VW)
   ) u_divider (
      .clock    (clock),
      .x_in     (x_ff),
      .radix_in (radix_ff),
      .quot_out (div_quot),
      .rem_out  (div_rem)
   );

   assign req_ok = (req_tuser == RADIX_DEC || req_tuser == RADIX_OCT ||
                    req_tuser == RADIX_HEX) &&
                   (req_tdata[LIMIT_LSB +: LIMIT_W] != '0);
   assign cnt_next = cnt_ff + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      radix_ff     <= radix_in;
      limit_ff     <= limit_in;
      cnt_ff       <= cnt_in;
      ptr_ff       <= ptr_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
      if (state_ff == ST_FIX) begin
         digits_ff[cnt_ff[IW-1:0]] <= div_rem;
      end
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      radix_in     = radix_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in     = req_tdata[VALUE_LSB +: VW];
               limit_in = req_tdata[LIMIT_LSB +: LIMIT_W];
               cnt_in   = '0;
               if (req_ok) begin
                  radix_in = radix_type'(req_tuser);
                  state_in = ST_DIV;
               end else begin
                  rsp_char_in  = '0;
                  rsp_count_in = '0;
                  rsp_err_in   = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_SEND;
               end
            end
         end
         ST_DIV: begin
            state_in = ST_FIX;
         end
         ST_FIX: begin
            x_in   = div_quot;
            cnt_in = cnt_next;
            if (div_quot == '0) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_SEND;
               if (cnt_next > limit_ff) begin
                  rsp_char_in  = '0;
                  rsp_count_in = '0;
                  rsp_err_in   = 1'b1;
               end else begin
                  // most significant digit goes out straight from the divider
                  rsp_char_in  = digit_ascii(div_rem);
                  rsp_count_in = cnt_next;
                  rsp_err_in   = 1'b0;
                  rsp_last_in  = (cnt_ff == '0);
                  ptr_in       = cnt_ff[IW-1:0];
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  // advance to the next lower digit
                  ptr_in      = ptr_ff - IW'(1);
                  rsp_char_in = digit_ascii(digits_ff[ptr_ff - IW'(1)]);
                  rsp_last_in = (ptr_ff == IW'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - COUNT_W - CHAR_W)'(0), rsp_count_ff, rsp_char_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* verif/integer_to_radix_ascii_checker.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_checker
// Watches both streams of the radix converter, predicts and compares digits.
// ----------------------------------------------------------------------------
// Every accepted request beat is expanded into the digit beats the converter
// should return (or its single error beat). These are queued in order, and
// each accepted response beat is compared field by field with the oldest
// entry. The number of failures and the number of beats still owed are
// handed back to the testbench top.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_checker #(
   parameter int VALUE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [i2ra_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [i2ra_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [i2ra_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            rsp_tlast,
   output int                              failures,
   output int                              owed_beats
);
   import i2ra_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0]  digit_char;
      logic [COUNT_W-1:0] digit_count;
      logic               error;
      logic               last;
   } digit_beat_type;

   localparam digit_beat_type ERROR_BEAT = '{digit_char: '0, digit_count: '0,
                                             error: 1'b1, last: 1'b1};

   digit_beat_type expected_digits [$];

   function automatic logic [63:0] value_mask();
      return (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
   endfunction

   // Expand one request into its digit beats, most significant digit first.
   function automatic void expand_digits(input logic [1:0]         radix_sel,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [LIMIT_W-1:0] limit);
      logic [63:0]    x;
      int             base;
      int             n;
      int             d;
      int             reversed [24];
      digit_beat_type beat;
      x = {32'd0, value} & value_mask();
      case (radix_sel)
         RADIX_DEC: base = 10;
         RADIX_OCT: base = 8;
         RADIX_HEX: base = 16;
         default:   base = 0;
      endcase
      if (base == 0 || limit == 0) begin
         expected_digits.push_back(ERROR_BEAT);
         return;
      end
      n = 0;
      do begin
         reversed[n] = int'(x % base);
         n++;
         x = x / base;
      end while (x != 0);
      if (n > int'(limit)) begin
         expected_digits.push_back(ERROR_BEAT);
         return;
      end
      for (int k = 0; k < n; k++) begin
         d = reversed[n - 1 - k];
         beat.digit_char  = (d < 10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h61 + d - 10);
         beat.digit_count = COUNT_W'(n);
         beat.error       = 1'b0;
         beat.last        = (k == n - 1);
         expected_digits.push_back(beat);
      end
   endfunction

   initial begin
      failures   = 0;
      owed_beats = 0;
   end

   always @(posedge clock) begin : watch
      digit_beat_type want;
      digit_beat_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expand_digits(req_tuser, req_tdata[VALUE_LSB +: VALUE_W],
                          req_tdata[LIMIT_LSB +: LIMIT_W]);
         if (rsp_tvalid && rsp_tready) begin
            got.digit_char  = rsp_tdata[CHAR_W-1:0];
            got.digit_count = rsp_tdata[CHAR_W +: COUNT_W];
            got.error       = rsp_tuser;
            got.last        = rsp_tlast;
            if (expected_digits.size() == 0) begin
               $error("unexpected response beat: char %0h count %0d error %0b last %0b",
                      got.digit_char, got.digit_count, got.error, got.last);
               failures++;
            end else begin
               want = expected_digits.pop_front();
               if (got.digit_char !== want.digit_char) begin
                  $error("digit_char: expected %0h, got %0h",
                         want.digit_char, got.digit_char);
                  failures++;
               end
               if (got.digit_count !== want.digit_count) begin
                  $error("digit_count: expected %0d, got %0d",
                         want.digit_count, got.digit_count);
                  failures++;
               end
               if (got.error !== want.error) begin
                  $error("error: expected %0b, got %0b", want.error, got.error);
                  failures++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  failures++;
               end
               // padding above the digit count must stay clear
               if (rsp_tdata[RSP_DATA_W-1:CHAR_W+COUNT_W] !== '0) begin
                  $error("tdata padding: expected 0, got %0h",
                         rsp_tdata[RSP_DATA_W-1:CHAR_W+COUNT_W]);
                  failures++;
               end
            end
         end
      end
      owed_beats = expected_digits.size();
   end

endmodule

/* verif/integer_to_radix_ascii_tb.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_tb
// Stimulus and verdict for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
// A directed set covers the digit limits at their edges, every radix, zero,
// full-scale values and the unused radix code. Random requests follow in
// phases of sender gaps and sink stalls, one of them with a long sink
// hold-off so that the converter backs up. The checker beside the block
// predicts and compares every response beat.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_tb;
   import i2ra_pkg::*;

   localparam logic [1:0] RADIX_UNUSED   = 2'd3;
   localparam int         ITEMS_PER_PHASE = 20;
   localparam int         HOLD_CYCLES     = 300;
   localparam int         SETTLE_CYCLES   = 40;
   localparam int         CYCLE_LIMIT     = 300000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int failures;
   int owed_beats;
   int cycles;
   int send_gap_pct;
   int sink_stall_pct;
   bit hold_request;

   radix_type radices [3] = '{RADIX_DEC, RADIX_OCT, RADIX_HEX};

   integer_to_radix_ascii #(.VALUE_BITS(32)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   integer_to_radix_ascii_checker #(.VALUE_BITS(32)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .owed_beats (owed_beats)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("integer_to_radix_ascii_tb: done, errors");
         $finish;
      end
   end

   // Sink: random stalls, or a long hold-off when asked for.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready = !reset && ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Offer one request beat from a falling edge and hold it until taken.
   task automatic offer_request(input logic [1:0]         radix_sel,
                                input logic [VALUE_W-1:0] value,
                                input logic [LIMIT_W-1:0] limit);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata                       = '0;
      req_tdata[VALUE_LSB +: VALUE_W] = value;
      req_tdata[LIMIT_LSB +: LIMIT_W] = limit;
      req_tuser                       = radix_sel;
      req_tvalid                      = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic offer_random();
      int                 width;
      logic [VALUE_W-1:0] value;
      logic [1:0]         radix_sel;
      logic [LIMIT_W-1:0] limit;
      // short values are common so that every digit count turns up
      width = $urandom_range(1, VALUE_W);
      value = $urandom;
      if (width < VALUE_W)
         value = value & ((32'd1 << width) - 32'd1);
      radix_sel = ($urandom_range(9) == 0) ? RADIX_UNUSED : radices[$urandom_range(2)];
      limit = ($urandom_range(4) == 0) ? LIMIT_W'($urandom_range(15))
                                       : LIMIT_W'($urandom_range(15, 8));
      offer_request(radix_sel, value, limit);
   endtask

   // Drop valid and wait for every owed beat.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (owed_beats != 0) @(negedge clock);
   endtask

   initial begin
      cycles         = 0;
      send_gap_pct   = 0;
      sink_stall_pct = 0;
      hold_request   = 1'b0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: limits at their edges, zero, full scale, every radix
      offer_request(RADIX_DEC, 32'd0,          4'd1);
      offer_request(RADIX_DEC, 32'd0,          4'd0);
      offer_request(RADIX_DEC, 32'hFFFF_FFFF,  4'd10);
      offer_request(RADIX_DEC, 32'hFFFF_FFFF,  4'd9);
      offer_request(RADIX_DEC, 32'hFFFF_FFFF,  4'd15);
      offer_request(RADIX_DEC, 32'd9,          4'd1);
      offer_request(RADIX_DEC, 32'd10,         4'd1);
      offer_request(RADIX_DEC, 32'd1234567890, 4'd15);
      offer_request(RADIX_OCT, 32'hFFFF_FFFF,  4'd11);
      offer_request(RADIX_OCT, 32'hFFFF_FFFF,  4'd10);
      offer_request(RADIX_OCT, 32'd7,          4'd1);
      offer_request(RADIX_OCT, 32'd8,          4'd2);
      offer_request(RADIX_OCT, 32'd0,          4'd15);
      offer_request(RADIX_HEX, 32'hFFFF_FFFF,  4'd8);
      offer_request(RADIX_HEX, 32'hFFFF_FFFF,  4'd7);
      offer_request(RADIX_HEX, 32'hABCD_EF01,  4'd8);
      offer_request(RADIX_HEX, 32'h0000_0010,  4'd2);
      offer_request(RADIX_HEX, 32'h0000_0010,  4'd1);
      offer_request(RADIX_HEX, 32'h1234_5678,  4'd0);
      offer_request(RADIX_UNUSED, 32'd5,       4'd15);
      offer_request(RADIX_UNUSED, 32'd0,       4'd0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_gap_pct = 53; sink_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  sink_stall_pct = 53; end
            default: begin send_gap_pct = 18; sink_stall_pct = 18; end
         endcase
         // back the converter up while requests keep coming
         if (phase == 2)
            hold_request = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            offer_random();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("integer_to_radix_ascii_tb: done, clean");
      else
         $display("integer_to_radix_ascii_tb: done, errors");
      $finish;
   end

endmodule
